FILE: rtl/core/tx_descriptor_ring_manager_core_assert.svh
// Assertion macros for the checker file of the transmit ring block.
// Each macro takes a label, a clock, an active-low reset, a condition and a
// consequence.
`ifndef TX_DESCRIPTOR_RING_MANAGER_CORE_ASSERT_SVH
`define TX_DESCRIPTOR_RING_MANAGER_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define TDRM_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tdrm check failed");

// The consequence must hold in the cycle after the condition.
`define TDRM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tdrm check failed");

`endif

FILE: rtl/core/tdrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tdrm_pkg;

  localparam int RING_DEPTH_DEF      = 4;
  localparam int MAX_FRAME_BYTES_DEF = 1792;

  localparam int OUTCOME_W = 3;
  localparam int SLOT_IDX_W = 2;
  localparam int PEND_W    = 3;
  localparam int LEN_W     = 16;
  localparam int STATUS_W  = 32;
  localparam int CMD_W     = 22;
  localparam int THRESH_W  = 6;
  localparam int SLOT_LEN_W = 11;
  localparam int CNT_W     = 32;
  localparam int BYTE_CNT_W = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 6'd8;
  localparam logic [LEN_W-1:0]    MIN_WIRE     = 16'd60;

  // Status word bits.
  localparam logic [STATUS_W-1:0] ST_OK       = 32'h0000_8000;
  localparam logic [STATUS_W-1:0] ST_UNDERRUN = 32'h0000_4000;
  localparam logic [STATUS_W-1:0] ST_OUTWIN   = 32'h2000_0000;
  localparam logic [STATUS_W-1:0] ST_ABORTED  = 32'h4000_0000;

  // Operation codes.
  localparam logic OP_SUBMIT   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  // Outcome codes.
  localparam logic [OUTCOME_W-1:0] OC_QUEUED   = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_BUSY     = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_DROPPED  = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_DONE_OK  = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_DONE_ERR = 3'd4;
  localparam logic [OUTCOME_W-1:0] OC_IN_PROG  = 3'd5;
  localparam logic [OUTCOME_W-1:0] OC_NONE     = 3'd6;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_EARLY_TX_THRESHOLD = 1'b0;

endpackage
`default_nettype wire

FILE: rtl/core/tdrm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface tdrm_in_if
  import tdrm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                op;
  logic [LEN_W-1:0]    frame_length;
  logic [STATUS_W-1:0] tx_status;

  modport source (output valid, op, frame_length, tx_status, input ready);
  modport sink   (input valid, op, frame_length, tx_status, output ready);
endinterface

interface tdrm_out_if
  import tdrm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OUTCOME_W-1:0]  outcome;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [CMD_W-1:0]      command_word;
  logic                  queue_halted;
  logic [PEND_W-1:0]     pending_count;
  logic [CNT_W-1:0]      packets_sent;
  logic [BYTE_CNT_W-1:0] bytes_sent;
  logic [CNT_W-1:0]      send_errors;
  logic [CNT_W-1:0]      frames_dropped;

  modport source (output valid, outcome, slot_index, command_word, queue_halted,
                  pending_count, packets_sent, bytes_sent, send_errors,
                  frames_dropped, input ready);
  modport sink   (input valid, outcome, slot_index, command_word, queue_halted,
                  pending_count, packets_sent, bytes_sent, send_errors,
                  frames_dropped, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tx_descriptor_ring_manager_core.sv
// Transmit descriptor ring manager.
//
// The input channel carries one item per request: a submit (op 0) with a
// frame length, or a completion report (op 1) with a descriptor status word.
// Every item produces exactly one result item on the output channel, with
// the outcome, the descriptor slot concerned, the command word of a queued
// frame and a snapshot of the ring occupancy, halted flag and counters.
// An item is captured in the input register at the edge that accepts it,
// the decision logic then loads the result register from it, and the result
// waits there until taken. Throughput is one item per clock while the
// receiver does not stall; the ring state and counters are updated in the
// same edge that loads the result register, so back-to-back items see each
// other's effects. If the receiver stalls, the result register holds and
// the input register takes one more item; then in_ch.ready drops until the
// result is taken. The user must write the early transmit threshold through
// the APB-style port only while the block is idle, which the block does not enforce; it reads back at address 0.
// A synchronous active-low reset empties the ring, clears the halted flag
// and all counters, loads the threshold with 8 and drops both valid flags.
`timescale 1ns / 1ps
`default_nettype none
module tx_descriptor_ring_manager_core
  import tdrm_pkg::*;
#(
  parameter int RING_DEPTH      = RING_DEPTH_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  tdrm_in_if.sink               in_ch,
  tdrm_out_if.source            out_ch,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [CFG_ADDR_W-1:0] paddr,
  input  wire  [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Pointers count modulo twice the ring depth so that full and empty differ.
  localparam int PTR_MOD = 2 * RING_DEPTH;
  localparam int PTR_W   = $clog2(PTR_MOD);
  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_MOD_W = PTR_W'(PTR_MOD);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(PTR_MOD - 1);
  localparam logic [PTR_W-1:0] DEPTH_W   = PTR_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0] DEPTH_M1  = PTR_W'(RING_DEPTH - 1);
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_FRAME_BYTES);

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] t;
    t = (ptr >= DEPTH_W) ? ptr - DEPTH_W : ptr;
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic [THRESH_W-1:0] thresh_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_EARLY_TX_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr) begin
      thresh_r <= pwdata[THRESH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_EARLY_TX_THRESHOLD) begin
      prdata = CFG_DATA_W'(thresh_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and result register handshake
  // ---------------------------------------------------------------------------
  logic                s1_valid_r;
  logic                s1_op_r;
  logic [LEN_W-1:0]    s1_len_r;
  logic [STATUS_W-1:0] s1_status_r;
  logic                out_valid_r;
  logic                s2_load;
  logic                in_take;

  assign s2_load      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s2_load;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r     <= in_ch.op;
      s1_len_r    <= in_ch.frame_length;
      s1_status_r <= in_ch.tx_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring state
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0]      submit_ptr_r, submit_ptr_nxt;
  logic [PTR_W-1:0]      retire_ptr_r, retire_ptr_nxt;
  logic                  halted_r, halted_nxt;
  logic [CNT_W-1:0]      ok_frames_r, ok_frames_nxt;
  logic [BYTE_CNT_W-1:0] ok_bytes_r, ok_bytes_nxt;
  logic [CNT_W-1:0]      err_frames_r, err_frames_nxt;
  logic [CNT_W-1:0]      drop_frames_r, drop_frames_nxt;
  logic [SLOT_LEN_W-1:0] slot_len_r [RING_DEPTH];

  logic [PTR_W-1:0]      pend;
  logic [SLOT_W-1:0]     sub_slot;
  logic [SLOT_W-1:0]     ret_slot;
  logic [LEN_W-1:0]      wire_len;
  logic                  len_bad;
  logic                  st_done;
  logic                  st_err;
  logic                  slot_wr;
  logic [OUTCOME_W-1:0]  outcome_nxt;
  logic [SLOT_W-1:0]     slot_nxt;
  logic [CMD_W-1:0]      cmd_nxt;
  logic [OUTCOME_W-1:0]  outcome_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [CMD_W-1:0]      cmd_r;

  // Occupancy: the difference of the pointers, brought back into range.
  always_comb begin
    pend = submit_ptr_r - retire_ptr_r;
    if (submit_ptr_r < retire_ptr_r) begin
      pend = pend + PTR_MOD_W;
    end
  end

  assign sub_slot = slot_of(submit_ptr_r);
  assign ret_slot = slot_of(retire_ptr_r);
  assign wire_len = (s1_len_r < MIN_WIRE) ? MIN_WIRE : s1_len_r;
  assign len_bad  = (s1_len_r == '0) || (s1_len_r > MAX_LEN);
  assign st_done  = (s1_status_r & (ST_OK | ST_UNDERRUN | ST_ABORTED)) != '0;
  assign st_err   = (s1_status_r & (ST_OUTWIN | ST_ABORTED)) != '0;

  always_comb begin
    submit_ptr_nxt  = submit_ptr_r;
    retire_ptr_nxt  = retire_ptr_r;
    halted_nxt      = halted_r;
    ok_frames_nxt   = ok_frames_r;
    ok_bytes_nxt    = ok_bytes_r;
    err_frames_nxt  = err_frames_r;
    drop_frames_nxt = drop_frames_r;
    slot_wr         = 1'b0;
    cmd_nxt         = '0;
    outcome_nxt     = OC_NONE;
    slot_nxt        = ret_slot;
    if (s1_op_r == OP_SUBMIT) begin
      slot_nxt = sub_slot;
      if (pend >= DEPTH_W) begin
        // Ring full: refuse and stop the submit side.
        halted_nxt  = 1'b1;
        outcome_nxt = OC_BUSY;
      end else if (len_bad) begin
        drop_frames_nxt = drop_frames_r + 1'b1;
        outcome_nxt     = OC_DROPPED;
      end else begin
        cmd_nxt        = {thresh_r, wire_len};
        slot_wr        = 1'b1;
        submit_ptr_nxt = ptr_next(submit_ptr_r);
        outcome_nxt    = OC_QUEUED;
        // This submit takes the last free descriptor.
        if (pend == DEPTH_M1) begin
          halted_nxt = 1'b1;
        end
      end
    end else begin
      if (pend == '0) begin
        outcome_nxt = OC_NONE;
      end else if (!st_done) begin
        outcome_nxt = OC_IN_PROG;
      end else begin
        if (st_err) begin
          err_frames_nxt = err_frames_r + 1'b1;
          outcome_nxt    = OC_DONE_ERR;
        end else begin
          ok_frames_nxt = ok_frames_r + 1'b1;
          ok_bytes_nxt  = ok_bytes_r + BYTE_CNT_W'(slot_len_r[ret_slot]);
          outcome_nxt   = OC_DONE_OK;
        end
        retire_ptr_nxt = ptr_next(retire_ptr_r);
      end
      // Wake the submit side once any descriptor is free after this report.
      if ((retire_ptr_nxt != retire_ptr_r) || (pend < DEPTH_W)) begin
        halted_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      submit_ptr_r  <= '0;
      retire_ptr_r  <= '0;
      halted_r      <= 1'b0;
      ok_frames_r   <= '0;
      ok_bytes_r    <= '0;
      err_frames_r  <= '0;
      drop_frames_r <= '0;
    end else if (s2_load) begin
      submit_ptr_r  <= submit_ptr_nxt;
      retire_ptr_r  <= retire_ptr_nxt;
      halted_r      <= halted_nxt;
      ok_frames_r   <= ok_frames_nxt;
      ok_bytes_r    <= ok_bytes_nxt;
      err_frames_r  <= err_frames_nxt;
      drop_frames_r <= drop_frames_nxt;
    end
  end

  // Stored lengths are read only for descriptors that a submit wrote, so the
  // array needs neither reset nor clearing on retire.
  always_ff @(posedge clk) begin
    if (s2_load && slot_wr) begin
      slot_len_r[sub_slot] <= s1_len_r[SLOT_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      outcome_r <= outcome_nxt;
      slot_r    <= slot_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

  // The state only moves when a new result is loaded, so the status fields
  // of a waiting result come straight from the state registers.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.outcome        = outcome_r;
  assign out_ch.slot_index     = SLOT_IDX_W'(slot_r);
  assign out_ch.command_word   = cmd_r;
  assign out_ch.queue_halted   = halted_r;
  assign out_ch.pending_count  = PEND_W'(pend);
  assign out_ch.packets_sent   = ok_frames_r;
  assign out_ch.bytes_sent     = ok_bytes_r;
  assign out_ch.send_errors    = err_frames_r;
  assign out_ch.frames_dropped = drop_frames_r;

endmodule
`default_nettype wire

FILE: rtl/core/tdrm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tx_descriptor_ring_manager_core_assert.svh"
module tdrm_checker
  import tdrm_pkg::*;
(
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire [OUTCOME_W-1:0] outcome,
  input wire [CMD_W-1:0]     command_word,
  input wire                 queue_halted
);

  // A result that is not taken stays offered.
  `TDRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A refused submit always leaves the submit side stopped.
  `TDRM_ASSERT_NOW(a_busy_halts, clk, rst_n, out_valid && (outcome == OC_BUSY), queue_halted)

  // Only a queued frame carries a command word.
  `TDRM_ASSERT_NOW(a_cmd_zero, clk, rst_n, out_valid && (outcome != OC_QUEUED), command_word == '0)

  // A queued frame is padded to the minimum wire length.
  `TDRM_ASSERT_NOW(a_cmd_pad, clk, rst_n, out_valid && (outcome == OC_QUEUED), command_word[15:0] >= MIN_WIRE)

endmodule

bind tx_descriptor_ring_manager_core tdrm_checker u_tdrm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .outcome      (out_ch.outcome),
  .command_word (out_ch.command_word),
  .queue_halted (out_ch.queue_halted)
);
`default_nettype wire

FILE: tb/tdrm_ring_checker.sv
`timescale 1ns / 1ps
module tdrm_ring_checker
  import tdrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tdrm_in_if                    in_mon,
  tdrm_out_if                   out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    results_due
);

  localparam int DEPTH    = RING_DEPTH_DEF;
  localparam int PTR_SPAN = 2 * DEPTH;
  localparam int MAX_LEN  = MAX_FRAME_BYTES_DEF;

  typedef struct packed {
    logic [OUTCOME_W-1:0]  outcome;
    logic [SLOT_IDX_W-1:0] slot;
    logic [CMD_W-1:0]      cmd;
    logic                  halted;
    logic [PEND_W-1:0]     pend;
    logic [CNT_W-1:0]      pkts;
    logic [BYTE_CNT_W-1:0] bytes;
    logic [CNT_W-1:0]      errs;
    logic [CNT_W-1:0]      drops;
  } ring_result_t;

  // Shadow copy of the ring and its counters.
  int unsigned           head_ptr;
  int unsigned           tail_ptr;
  logic [SLOT_LEN_W-1:0] len_mem [DEPTH];
  logic                  halted;
  logic [CNT_W-1:0]      pkt_total;
  logic [BYTE_CNT_W-1:0] byte_total;
  logic [CNT_W-1:0]      err_total;
  logic [CNT_W-1:0]      drop_total;
  logic [THRESH_W-1:0]   thresh;

  ring_result_t predicted_results [$];
  ring_result_t want;

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  function automatic int unsigned in_flight();
    return (head_ptr + PTR_SPAN - tail_ptr) % PTR_SPAN;
  endfunction

  // Applies one item to the shadow ring and returns the result it causes.
  function automatic ring_result_t ring_advance(logic op, logic [LEN_W-1:0] len,
                                                logic [STATUS_W-1:0] status);
    ring_result_t     r;
    logic [LEN_W-1:0] padded_len;
    int unsigned      idx;
    r = '0;
    if (op == OP_SUBMIT) begin
      idx = head_ptr % DEPTH;
      if (in_flight() >= DEPTH) begin
        halted    = 1'b1;
        r.outcome = OC_BUSY;
      end else if (len == '0 || len > LEN_W'(MAX_LEN)) begin
        drop_total = drop_total + 1'b1;
        r.outcome  = OC_DROPPED;
      end else begin
        padded_len   = (len < MIN_WIRE) ? MIN_WIRE : len;
        r.cmd        = {thresh, padded_len};
        len_mem[idx] = len[SLOT_LEN_W-1:0];
        head_ptr     = (head_ptr + 1) % PTR_SPAN;
        if (in_flight() >= DEPTH) halted = 1'b1;
        r.outcome = OC_QUEUED;
      end
    end else begin
      idx = tail_ptr % DEPTH;
      if (in_flight() == 0) begin
        r.outcome = OC_NONE;
      end else if ((status & (ST_OK | ST_UNDERRUN | ST_ABORTED)) == '0) begin
        r.outcome = OC_IN_PROG;
      end else begin
        if ((status & (ST_OUTWIN | ST_ABORTED)) != '0) begin
          err_total = err_total + 1'b1;
          r.outcome = OC_DONE_ERR;
        end else begin
          pkt_total  = pkt_total + 1'b1;
          byte_total = byte_total + BYTE_CNT_W'(len_mem[idx]);
          r.outcome  = OC_DONE_OK;
        end
        len_mem[idx] = '0;
        tail_ptr     = (tail_ptr + 1) % PTR_SPAN;
      end
      if (halted && in_flight() < DEPTH) halted = 1'b0;
    end
    r.slot   = idx[SLOT_IDX_W-1:0];
    r.halted = halted;
    r.pend   = PEND_W'(in_flight());
    r.pkts   = pkt_total;
    r.bytes  = byte_total;
    r.errs   = err_total;
    r.drops  = drop_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] expected,
                                      logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head_ptr   = 0;
      tail_ptr   = 0;
      halted     = 1'b0;
      pkt_total  = '0;
      byte_total = '0;
      err_total  = '0;
      drop_total = '0;
      thresh     = THRESH_RESET;
      for (int i = 0; i < DEPTH; i++) len_mem[i] = '0;
      predicted_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_EARLY_TX_THRESHOLD)
        thresh = pwdata[THRESH_W-1:0];

      if (out_mon.valid && out_mon.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result item with no prediction waiting, outcome %0d",
                 out_mon.outcome);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("outcome", 64'(want.outcome), 64'(out_mon.outcome));
          check_field("slot_index", 64'(want.slot), 64'(out_mon.slot_index));
          check_field("command_word", 64'(want.cmd), 64'(out_mon.command_word));
          check_field("queue_halted", 64'(want.halted), 64'(out_mon.queue_halted));
          check_field("pending_count", 64'(want.pend), 64'(out_mon.pending_count));
          check_field("packets_sent", 64'(want.pkts), 64'(out_mon.packets_sent));
          check_field("bytes_sent", 64'(want.bytes), 64'(out_mon.bytes_sent));
          check_field("send_errors", 64'(want.errs), 64'(out_mon.send_errors));
          check_field("frames_dropped", 64'(want.drops), 64'(out_mon.frames_dropped));
        end
      end

      if (in_mon.valid && in_mon.ready)
        predicted_results.push_back(ring_advance(in_mon.op, in_mon.frame_length,
                                                 in_mon.tx_status));
    end
    results_due = predicted_results.size();
  end

endmodule

FILE: tb/tb_tx_descriptor_ring_manager_core.sv
`timescale 1ns / 1ps
module tb_tx_descriptor_ring_manager_core;
  import tdrm_pkg::*;

  localparam int MAX_LEN         = MAX_FRAME_BYTES_DEF;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 175;
  // Idle time after the last result covers any slack before a register write.
  localparam int DRAIN_CYCLES    = 8;
  // Long enough that the result register and the input register both fill.
  localparam int HOLD_CYCLES     = 80;
  localparam int CYCLE_LIMIT     = 500000;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  tdrm_in_if  in_ch ();
  tdrm_out_if out_ch ();

  int mismatches;
  int results_due;
  int cycle_count;

  // Random idling on each side can be switched off per phase. The hold-off
  // request asks the receiver for one long stall while items keep coming.
  logic src_idling;
  logic sink_idling;
  logic hold_req;

  tx_descriptor_ring_manager_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tdrm_ring_checker ring_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hung handshake or a lost result ends here instead of running forever.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tx_descriptor_ring_manager_core NOT OK");
      $finish;
    end
  end

  // Receiver side. Inputs move only at the falling edge, so the block and the
  // checker see settled values at every rising edge.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offers one item and returns at the falling edge after it was accepted.
  // Valid stays high when the next call follows directly, so back-to-back
  // items go through with no bubble.
  task automatic send_item(logic op, logic [LEN_W-1:0] len, logic [STATUS_W-1:0] st);
    if (src_idling && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.op           = op;
    in_ch.frame_length = len;
    in_ch.tx_status    = st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Two-phase register write: setup cycle, then the access cycle in which
  // the register takes the new value.
  task automatic write_threshold(logic [CFG_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_EARLY_TX_THRESHOLD, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Waits until every predicted result has come back, then idles for DRAIN_CYCLES so
  // nothing is still moving through the pipeline.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Builds one random item. Most submits carry a legal length and most
  // completions carry a finished status, so the ring really fills and drains;
  // the rest covers bad lengths, in-progress status and raw random words.
  function automatic void pick_ring_item(int submit_pct, output logic op,
                                         output logic [LEN_W-1:0] len,
                                         output logic [STATUS_W-1:0] st);
    int k;
    op = ($urandom_range(0, 99) < submit_pct) ? OP_SUBMIT : OP_COMPLETE;

    k = $urandom_range(0, 99);
    if (k < 5)       len = '0;
    else if (k < 15) len = LEN_W'($urandom_range(MAX_LEN + 1, 65535));
    else if (k < 22) len = LEN_W'($urandom());
    else if (k < 35) len = LEN_W'($urandom_range(1, 59));
    else             len = LEN_W'($urandom_range(1, MAX_LEN));

    st = $urandom();
    k = $urandom_range(0, 99);
    if (k < 45) begin
      // Finished cleanly, underrun bit left random.
      st = (st | ST_OK) & ~(ST_OUTWIN | ST_ABORTED);
    end else if (k < 60) begin
      st = st | (($urandom_range(0, 1) != 0) ? ST_ABORTED : (ST_OK | ST_OUTWIN));
    end else if (k < 70) begin
      st = (st | ST_UNDERRUN) & ~(ST_OK | ST_ABORTED | ST_OUTWIN);
    end else if (k < 85) begin
      // Still owned by the hardware; out-of-window may be set but must not retire.
      st = st & ~(ST_OK | ST_UNDERRUN | ST_ABORTED);
    end
  endfunction

  initial begin
    logic                op;
    logic [LEN_W-1:0]    len;
    logic [STATUS_W-1:0] st;
    int                  submit_pct;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_SUBMIT;
    in_ch.frame_length = '0;
    in_ch.tx_status    = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    src_idling         = 1'b1;
    sink_idling        = 1'b1;
    hold_req           = 1'b0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, with the threshold still at its reset value.
    // A completion on an empty ring reports nothing pending.
    send_item(OP_COMPLETE, 16'd0, ST_OK);
    // Zero, one past the largest and the largest field value are all dropped.
    send_item(OP_SUBMIT, 16'd0, '0);
    send_item(OP_SUBMIT, LEN_W'(MAX_LEN + 1), '0);
    send_item(OP_SUBMIT, 16'hFFFF, 32'hFFFF_FFFF);
    // Short frames are padded to the minimum wire length; the fourth queued
    // frame fills the ring and halts the submit side.
    send_item(OP_SUBMIT, 16'd1, '0);
    send_item(OP_SUBMIT, 16'd59, '0);
    send_item(OP_SUBMIT, MIN_WIRE, '0);
    send_item(OP_SUBMIT, LEN_W'(MAX_LEN), '0);
    // A full ring refuses as busy before it looks at the length.
    send_item(OP_SUBMIT, 16'd0, '0);
    send_item(OP_SUBMIT, 16'd100, '0);
    // Not done, even with the out-of-window bit: nothing retires.
    send_item(OP_COMPLETE, 16'd0, '0);
    send_item(OP_COMPLETE, 16'd0, ST_OUTWIN);
    // Clean finish retires one entry and wakes the submit side.
    send_item(OP_COMPLETE, 16'd0, ST_OK);
    send_item(OP_COMPLETE, 16'd0, ST_ABORTED);
    send_item(OP_COMPLETE, 16'd0, ST_UNDERRUN);
    send_item(OP_COMPLETE, 16'd0, ST_OK | ST_OUTWIN);
    send_item(OP_COMPLETE, 16'd0, ST_OK);
    send_item(OP_SUBMIT, 16'd1500, '0);
    send_item(OP_COMPLETE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_SUBMIT, 16'd60, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases. Each starts from an idle block with a new threshold:
    // the two extremes first, then full random words whose upper bits the
    // register must ignore. Phases cycle through filling the ring, draining it
    // and an even mix; phase 3 has no sender idling, phase 4 no receiver
    // idling, and the last phase runs flat out on both sides.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0)      write_threshold('0);
      else if (ph == 1) write_threshold(32'd63);
      else              write_threshold($urandom());

      src_idling  = (ph != 3 && ph != NUM_PHASES - 1);
      sink_idling = (ph != 4 && ph != NUM_PHASES - 1);
      case (ph % 3)
        0: begin
          submit_pct = 70;
        end
        1: begin
          submit_pct = 35;
        end
        default: begin
          submit_pct = 50;
        end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // One long receiver stall while the sender keeps pushing.
        if (ph == 2 && n == 30) hold_req = 1'b1;
        pick_ring_item(submit_pct, op, len, st);
        send_item(op, len, st);
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb_tx_descriptor_ring_manager_core OK");
    end else begin
      $display("tb_tx_descriptor_ring_manager_core NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tdrm_pkg.sv
rtl/core/tdrm_ifs.sv
rtl/core/tx_descriptor_ring_manager_core.sv
rtl/core/tdrm_checker.sv
tb/tdrm_ring_checker.sv
tb/tb_tx_descriptor_ring_manager_core.sv
